// ===== sv/bbct_pkg.sv =====
// ----------------------------------------------------------------------------
// bbct_pkg: shared types and constants for the blob contour tracer
// Item kinds, result status codes, mask codes, register indexes and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package bbct_pkg;

   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 256;
   localparam int COUNT_W        = 20;
   localparam int COORD_W        = 8;
   localparam int REG_W          = 9;

   // item kinds (req_tuser)
   localparam logic [1:0] KIND_LOAD  = 2'd0;
   localparam logic [1:0] KIND_START = 2'd1;
   localparam logic [1:0] KIND_STEP  = 2'd2;
   localparam logic [1:0] KIND_MASK  = 2'd3;

   // result status (rsp_tuser)
   localparam logic [1:0] ST_POINT = 2'd0;
   localparam logic [1:0] ST_DONE  = 2'd1;
   localparam logic [1:0] ST_OOB   = 2'd2;
   localparam logic [1:0] ST_MASK  = 2'd3;

   // mask entry codes
   localparam logic [1:0] MK_NONE  = 2'd0;
   localparam logic [1:0] MK_LEFT  = 2'd1;
   localparam logic [1:0] MK_RIGHT = 2'd2;

   // configuration register indexes
   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   typedef struct packed {
      logic       clr_en;
      logic       take;
      logic       load_wr;
      logic       mask_rd;
      logic       start_eval;
      logic       step_eval;
      logic       rd_en;
      logic [1:0] rd_sel;
      logic       decide;
      logic       decide_start;
      logic       mark_l;
      logic       mark_r;
      logic       mask_ans;
      logic       emit;
   } bbct_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic start_oob;
      logic step_skip;
      logic out_free;
   } bbct_sts_type;

endpackage

// ===== sv/bbct_ctrl.sv =====
// ----------------------------------------------------------------------------
// bbct_ctrl: sequencer of the contour tracer
// Clears the mask store after reset, takes one item at a time and walks the
// datapath through neighbor reads, the move decision, mark writes and output.
// ----------------------------------------------------------------------------
module bbct_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [1:0]            req_tuser,
   input  bbct_pkg::bbct_sts_type sts,
   output bbct_pkg::bbct_cmd_type cmd
);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_START, S_STEP, S_MASK, S_RD, S_DECIDE, S_MARKL, S_MARKR,
      S_EMIT
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] rd_idx_ff, rd_idx_in;
   logic       mode_start_ff, mode_start_in;

   always_comb begin
      state_in      = state_ff;
      rd_idx_in     = rd_idx_ff;
      mode_start_in = mode_start_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (sts.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               unique case (req_tuser)
                  bbct_pkg::KIND_LOAD:  state_in = S_IDLE;
                  bbct_pkg::KIND_START: state_in = S_START;
                  bbct_pkg::KIND_STEP:  state_in = S_STEP;
                  default:              state_in = S_MASK;
               endcase
            end
         end
         S_START: begin
            rd_idx_in     = 2'd0;
            mode_start_in = 1'b1;
            state_in      = sts.start_oob ? S_EMIT : S_RD;
         end
         S_STEP: begin
            rd_idx_in     = 2'd0;
            mode_start_in = 1'b0;
            state_in      = sts.step_skip ? S_EMIT : S_RD;
         end
         S_MASK:   state_in = S_EMIT;
         S_RD: begin
            rd_idx_in = rd_idx_ff + 2'd1;
            if (rd_idx_ff == 2'd3) state_in = S_DECIDE;
         end
         S_DECIDE: state_in = S_MARKL;
         S_MARKL:  state_in = S_MARKR;
         S_MARKR:  state_in = S_EMIT;
         S_EMIT: begin
            if (sts.out_free) state_in = S_IDLE;
         end
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         rd_idx_ff     <= 2'd0;
         mode_start_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_idx_ff     <= rd_idx_in;
         mode_start_ff <= mode_start_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      cmd              = '0;
      cmd.clr_en       = (state_ff == S_CLEAR);
      cmd.take         = (state_ff == S_IDLE) && req_tvalid;
      cmd.load_wr      = cmd.take && (req_tuser == bbct_pkg::KIND_LOAD);
      cmd.mask_rd      = cmd.take && (req_tuser == bbct_pkg::KIND_MASK);
      cmd.start_eval   = (state_ff == S_START);
      cmd.step_eval    = (state_ff == S_STEP);
      cmd.rd_en        = (state_ff == S_RD);
      cmd.rd_sel       = rd_idx_ff;
      cmd.decide       = (state_ff == S_DECIDE);
      cmd.decide_start = mode_start_ff;
      cmd.mark_l       = (state_ff == S_MARKL);
      cmd.mark_r       = (state_ff == S_MARKR);
      cmd.mask_ans     = (state_ff == S_MASK);
      cmd.emit         = (state_ff == S_EMIT) && sts.out_free;
   end

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.out_free)
      else $error("result loaded while output register busy");

   a_reads_then_decide: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD && rd_idx_ff == 2'd3) |=> (state_ff == S_DECIDE))
      else $error("neighbor reads not followed by decision");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (cmd.take && req_tuser != bbct_pkg::KIND_LOAD) |=> !req_tready)
      else $error("ready again before result of item");

endmodule

// ===== sv/bbct_dp.sv =====
// ----------------------------------------------------------------------------
// bbct_dp: datapath of the contour tracer
// Image and mask stores, trace position, heading and count, the
// wall-following move decision and the result output register.
// ----------------------------------------------------------------------------
module bbct_dp #(
   parameter int MAX_WIDTH  = bbct_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bbct_pkg::DEF_MAX_HEIGHT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  bbct_pkg::bbct_cmd_type              cmd,
   output bbct_pkg::bbct_sts_type              sts,
   input  logic [bbct_pkg::COORD_W-1:0]        req_x,
   input  logic [bbct_pkg::COORD_W-1:0]        req_y,
   input  logic                                req_pixel,
   input  logic [bbct_pkg::COORD_W-1:0]        w_m1,
   input  logic [bbct_pkg::COORD_W-1:0]        h_m1,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [bbct_pkg::COORD_W-1:0]        rsp_x,
   output logic [bbct_pkg::COORD_W-1:0]        rsp_y,
   output logic [bbct_pkg::COUNT_W-1:0]        rsp_count,
   output logic [1:0]                          rsp_status,
   output logic [1:0]                          rsp_mask
);

   localparam int SW    = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
   localparam int SH    = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;
   localparam int XB    = $clog2(SW);
   localparam int YB    = $clog2(SH);
   localparam int AB    = XB + YB;
   localparam int DEPTH = 1 << AB;
   localparam int CW    = bbct_pkg::COORD_W;
   localparam int NW    = bbct_pkg::COUNT_W;

   typedef enum logic [1:0] {HD_UP, HD_RIGHT, HD_DOWN, HD_LEFT} heading_type;

   function automatic logic [AB-1:0] cell_addr(input logic [CW-1:0] x,
                                               input logic [CW-1:0] y);
      cell_addr = {y[YB-1:0], x[XB-1:0]};
   endfunction

   function automatic logic in_store(input logic [CW-1:0] x, input logic [CW-1:0] y);
      in_store = ({1'b0, x} < 9'(SW)) && ({1'b0, y} < 9'(SH));
   endfunction

   logic        img_mem  [DEPTH];
   logic [1:0]  mask_mem [DEPTH];

   // trace state
   logic [CW-1:0] cur_x_ff, cur_y_ff, start_x_ff, start_y_ff;
   heading_type   head_ff;
   logic [NW-1:0] count_ff;
   logic          active_ff;
   logic [AB-1:0] clr_addr_ff;

   // item and work registers
   logic [CW-1:0] item_x_ff, item_y_ff;
   logic          nb_ff [4];
   logic [1:0]    mask_q_ff;
   logic          ml_ff, mr_ff;
   logic [CW-1:0] mk_x_ff, mk_y_ff;
   logic [CW-1:0] res_x_ff, res_y_ff;
   logic [1:0]    res_st_ff, res_mask_ff;

   // output register
   logic          rsp_valid_ff;
   logic [CW-1:0] rsp_x_ff, rsp_y_ff;
   logic [NW-1:0] rsp_count_ff;
   logic [1:0]    rsp_status_ff, rsp_mask_ff;

   // ---------------------------------------------------------------- decision
   logic          gu, gr, gd, gl, x_lt, at_start, isolated;
   logic [CW-1:0] nx, ny;
   heading_type   nh;
   logic [1:0]    res;
   logic          ml, mr;

   always_comb begin
      gu       = (cur_y_ff != '0) && nb_ff[0];
      gr       = (cur_x_ff < w_m1) && nb_ff[1];
      gd       = (cur_y_ff < h_m1) && nb_ff[2];
      gl       = (cur_x_ff != '0) && nb_ff[3];
      x_lt     = (cur_x_ff < w_m1);
      at_start = (cur_x_ff == start_x_ff) && (cur_y_ff == start_y_ff);
      isolated = !(gu || gr || gd || gl);
      nx  = cur_x_ff;
      ny  = cur_y_ff;
      nh  = head_ff;
      res = bbct_pkg::ST_POINT;
      ml  = 1'b0;
      mr  = 1'b0;
      unique case (head_ff)
         HD_UP: begin
            if (gl) begin
               nx = cur_x_ff - 8'd1; nh = HD_LEFT;
            end else begin
               ml = 1'b1;
               if (gu) begin
                  ny = cur_y_ff - 8'd1; nh = HD_UP;
               end else if (at_start) begin
                  res = bbct_pkg::ST_DONE;
               end else if (gr) begin
                  nx = cur_x_ff + 8'd1; nh = HD_RIGHT;
               end else begin
                  mr = x_lt;
                  if (cur_y_ff >= h_m1) res = bbct_pkg::ST_OOB;
                  else begin
                     ny = cur_y_ff + 8'd1; nh = HD_DOWN;
                  end
               end
            end
         end
         HD_RIGHT: begin
            if (gu) begin
               ny = cur_y_ff - 8'd1; nh = HD_UP;
            end else if (at_start && count_ff > NW'(1)) begin
               res = bbct_pkg::ST_DONE;
            end else if (gr) begin
               nx = cur_x_ff + 8'd1; nh = HD_RIGHT;
            end else begin
               mr = x_lt;
               if (gd) begin
                  ny = cur_y_ff + 8'd1; nh = HD_DOWN;
               end else if (cur_x_ff == '0) begin
                  res = bbct_pkg::ST_OOB;
               end else begin
                  nx = cur_x_ff - 8'd1; nh = HD_LEFT;
               end
            end
         end
         HD_DOWN: begin
            if (at_start) begin
               res = bbct_pkg::ST_DONE;
            end else if (gr) begin
               nx = cur_x_ff + 8'd1; nh = HD_RIGHT;
            end else begin
               mr = x_lt;
               if (gd) begin
                  ny = cur_y_ff + 8'd1; nh = HD_DOWN;
               end else if (gl) begin
                  nx = cur_x_ff - 8'd1; nh = HD_LEFT;
               end else begin
                  ml = 1'b1;
                  if (cur_y_ff == '0) res = bbct_pkg::ST_OOB;
                  else begin
                     ny = cur_y_ff - 8'd1; nh = HD_UP;
                  end
               end
            end
         end
         default: begin
            if (gd) begin
               ny = cur_y_ff + 8'd1; nh = HD_DOWN;
            end else if (gl) begin
               nx = cur_x_ff - 8'd1; nh = HD_LEFT;
            end else begin
               ml = 1'b1;
               if (gu) begin
                  ny = cur_y_ff - 8'd1; nh = HD_UP;
               end else if (at_start) begin
                  res = bbct_pkg::ST_DONE;
               end else if (cur_x_ff >= w_m1) begin
                  res = bbct_pkg::ST_OOB;
               end else begin
                  nx = cur_x_ff + 8'd1; nh = HD_RIGHT;
               end
            end
         end
      endcase
   end

   // ---------------------------------------------------------------- status
   always_comb begin
      sts.clr_last  = (clr_addr_ff == '1);
      sts.start_oob = (item_x_ff > w_m1) || (item_y_ff > h_m1);
      sts.step_skip = !active_ff || (cur_x_ff > w_m1) || (cur_y_ff > h_m1);
      sts.out_free  = !rsp_valid_ff || rsp_ready;
   end

   // ---------------------------------------------------------------- image store
   logic [CW-1:0] rd_x, rd_y;

   always_comb begin
      rd_x = cur_x_ff;
      rd_y = cur_y_ff;
      case (cmd.rd_sel)
         2'd0:    rd_y = cur_y_ff - 8'd1;
         2'd1:    rd_x = cur_x_ff + 8'd1;
         2'd2:    rd_y = cur_y_ff + 8'd1;
         default: rd_x = cur_x_ff - 8'd1;
      endcase
   end

   // out-of-range neighbor reads are masked by the edge guards above
   always_ff @(posedge clock) begin
      if (cmd.load_wr && in_store(req_x, req_y)) img_mem[cell_addr(req_x, req_y)] <= req_pixel;
      if (cmd.rd_en) nb_ff[cmd.rd_sel] <= img_mem[cell_addr(rd_x, rd_y)];
   end

   // ---------------------------------------------------------------- mask store
   logic          mw_en;
   logic [AB-1:0] mw_addr;
   logic [1:0]    mw_data;

   always_comb begin
      mw_en   = 1'b0;
      mw_addr = '0;
      mw_data = bbct_pkg::MK_NONE;
      if (cmd.clr_en) begin
         mw_en   = 1'b1;
         mw_addr = clr_addr_ff;
      end else if (cmd.load_wr && in_store(req_x, req_y)) begin
         mw_en   = 1'b1;
         mw_addr = cell_addr(req_x, req_y);
      end else if (cmd.start_eval && !sts.start_oob) begin
         mw_en   = 1'b1;
         mw_addr = cell_addr(item_x_ff, item_y_ff);
         mw_data = bbct_pkg::MK_LEFT;
      end else if (cmd.mark_l && ml_ff) begin
         mw_en   = 1'b1;
         mw_addr = cell_addr(mk_x_ff, mk_y_ff);
         mw_data = bbct_pkg::MK_LEFT;
      end else if (cmd.mark_r && mr_ff) begin
         mw_en   = 1'b1;
         mw_addr = cell_addr(mk_x_ff + 8'd1, mk_y_ff);
         mw_data = bbct_pkg::MK_RIGHT;
      end
   end

   always_ff @(posedge clock) begin
      if (mw_en) mask_mem[mw_addr] <= mw_data;
      if (cmd.mask_rd) mask_q_ff <= mask_mem[cell_addr(req_x, req_y)];
   end

   // ---------------------------------------------------------------- trace state
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         start_x_ff   <= '0;
         start_y_ff   <= '0;
         head_ff      <= HD_RIGHT;
         count_ff     <= '0;
         active_ff    <= 1'b0;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clr_en) clr_addr_ff <= clr_addr_ff + AB'(1);
         if (cmd.start_eval) begin
            active_ff <= 1'b0;
            if (sts.start_oob) begin
               count_ff <= '0;
            end else begin
               cur_x_ff   <= item_x_ff;
               cur_y_ff   <= item_y_ff;
               start_x_ff <= item_x_ff;
               start_y_ff <= item_y_ff;
               head_ff    <= HD_RIGHT;
               count_ff   <= NW'(1);
            end
         end
         if (cmd.step_eval && sts.step_skip) active_ff <= 1'b0;
         if (cmd.decide) begin
            if (cmd.decide_start) begin
               active_ff <= !isolated;
            end else if (res == bbct_pkg::ST_POINT) begin
               cur_x_ff <= nx;
               cur_y_ff <= ny;
               head_ff  <= nh;
               if (count_ff != '1) count_ff <= count_ff + NW'(1);
            end else begin
               active_ff <= 1'b0;
            end
         end
         if (cmd.emit) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // ---------------------------------------------------------------- payload
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         item_x_ff <= req_x;
         item_y_ff <= req_y;
      end
      if (cmd.start_eval) begin
         res_x_ff    <= item_x_ff;
         res_y_ff    <= item_y_ff;
         res_st_ff   <= bbct_pkg::ST_OOB;
         res_mask_ff <= bbct_pkg::MK_NONE;
      end
      if (cmd.step_eval) begin
         res_x_ff    <= cur_x_ff;
         res_y_ff    <= cur_y_ff;
         res_st_ff   <= active_ff ? bbct_pkg::ST_OOB : bbct_pkg::ST_DONE;
         res_mask_ff <= bbct_pkg::MK_NONE;
      end
      if (cmd.mask_ans) begin
         res_x_ff    <= item_x_ff;
         res_y_ff    <= item_y_ff;
         res_st_ff   <= bbct_pkg::ST_MASK;
         res_mask_ff <= in_store(item_x_ff, item_y_ff) ? mask_q_ff : bbct_pkg::MK_NONE;
      end
      if (cmd.decide) begin
         mk_x_ff     <= cur_x_ff;
         mk_y_ff     <= cur_y_ff;
         res_mask_ff <= bbct_pkg::MK_NONE;
         if (cmd.decide_start) begin
            ml_ff     <= 1'b0;
            mr_ff     <= isolated && x_lt;
            res_x_ff  <= cur_x_ff;
            res_y_ff  <= cur_y_ff;
            res_st_ff <= isolated ? bbct_pkg::ST_DONE : bbct_pkg::ST_POINT;
         end else begin
            ml_ff     <= ml;
            mr_ff     <= mr;
            res_st_ff <= res;
            res_x_ff  <= (res == bbct_pkg::ST_POINT) ? nx : cur_x_ff;
            res_y_ff  <= (res == bbct_pkg::ST_POINT) ? ny : cur_y_ff;
         end
      end
      if (cmd.emit) begin
         rsp_x_ff      <= res_x_ff;
         rsp_y_ff      <= res_y_ff;
         rsp_count_ff  <= count_ff;
         rsp_status_ff <= res_st_ff;
         rsp_mask_ff   <= res_mask_ff;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_x      = rsp_x_ff;
   assign rsp_y      = rsp_y_ff;
   assign rsp_count  = rsp_count_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_mask   = rsp_mask_ff;

   a_one_mask_writer: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clr_en, cmd.load_wr, cmd.start_eval, cmd.mark_l, cmd.mark_r}))
      else $error("more than one mask store writer");

   // mask reads may come while a trace is running
   a_active_means_point: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && active_ff && res_st_ff != bbct_pkg::ST_MASK)
         |-> (res_st_ff == bbct_pkg::ST_POINT))
      else $error("trace still active on a final result");

   a_start_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.start_eval && !sts.start_oob) |=> (count_ff == NW'(1)) && !active_ff)
      else $error("start did not restart the count");

endmodule

// ===== sv/binary_blob_contour_tracer.sv =====
// ----------------------------------------------------------------------------
// binary_blob_contour_tracer: 4-connected outer boundary walker
// Stores a binary image, then follows the outline of a blob one pixel per
// step item, keeping left-edge / right-exclusion marks in a mask store.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  req      in   req_tvalid/tready  tuser: kind; tdata: coord_x, coord_y, pixel_value
//  rsp      out  rsp_tvalid/tready  tuser: status; tdata: point_x, point_y, count, mask
//  csr      in   csr_we             csr_addr: register index; csr_wdata: value
//
//  A load gives no result. A mask read goes through S_MASK to S_EMIT. Start and step
//  go through four neighbor reads, the decision and two mark writes on the single-port
//  image and mask stores to S_EMIT; out-of-image start and idle step go straight there.
//  After reset a clearing pass zeroes the mask store, one entry per cycle
//  (65536 entries at the default size); no item is taken until it ends.
//  A held result stalls only the next result; the next item is taken meanwhile.
// ----------------------------------------------------------------------------
module binary_blob_contour_tracer #(
   parameter int MAX_WIDTH  = bbct_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bbct_pkg::DEF_MAX_HEIGHT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // kind
   input  logic [23:0] req_tdata,   // coord_x[7:0], coord_y[15:8], pixel_value[16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [1:0]  rsp_tuser,   // status
   output logic [39:0] rsp_tdata,   // point_x[7:0], point_y[15:8],
                                    // points_so_far[35:16], mask_value[37:36]
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [8:0]  csr_wdata
);

   localparam logic [8:0] CAP_W = 9'((MAX_WIDTH < 256) ? MAX_WIDTH : 256);
   localparam logic [8:0] CAP_H = 9'((MAX_HEIGHT < 256) ? MAX_HEIGHT : 256);

   // working size, clamped to 1..cap when written
   logic [8:0] width_ff, width_in, height_ff, height_in;

   always_comb begin
      if (csr_wdata == 9'd0)       width_in = 9'd1;
      else if (csr_wdata > CAP_W)  width_in = CAP_W;
      else                         width_in = csr_wdata;
      if (csr_wdata == 9'd0)       height_in = 9'd1;
      else if (csr_wdata > CAP_H)  height_in = CAP_H;
      else                         height_in = csr_wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CAP_W;
         height_ff <= CAP_H;
      end else if (csr_we) begin
         if (csr_addr == bbct_pkg::CSR_WIDTH)  width_ff  <= width_in;
         if (csr_addr == bbct_pkg::CSR_HEIGHT) height_ff <= height_in;
      end
   end

   logic [7:0] w_m1, h_m1;
   logic [8:0] w_dec, h_dec;

   assign w_dec = width_ff - 9'd1;
   assign h_dec = height_ff - 9'd1;
   assign w_m1  = w_dec[7:0];
   assign h_m1  = h_dec[7:0];

   bbct_pkg::bbct_cmd_type cmd;
   bbct_pkg::bbct_sts_type sts;
   logic [19:0]            rsp_count;
   logic [1:0]             rsp_mask;
   logic [7:0]             rsp_x, rsp_y;

   bbct_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .sts        (sts),
      .cmd        (cmd)
   );

   bbct_dp #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_x      (req_tdata[7:0]),
      .req_y      (req_tdata[15:8]),
      .req_pixel  (req_tdata[16]),
      .w_m1       (w_m1),
      .h_m1       (h_m1),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_x      (rsp_x),
      .rsp_y      (rsp_y),
      .rsp_count  (rsp_count),
      .rsp_status (rsp_tuser),
      .rsp_mask   (rsp_mask)
   );

   assign rsp_tdata = {2'b00, rsp_mask, rsp_count, rsp_y, rsp_x};

endmodule

// ===== bench/binary_blob_contour_tracer_tb.sv =====
// ----------------------------------------------------------------------------
// binary_blob_contour_tracer_tb: self-checking bench for the contour tracer
// Loads small binary images, starts traces on blob edges and steps them
// around, mixing in mask reads and stray items. Every result is predicted
// from the bench's own copy of the image, mask and walk state and checked
// field by field, with random stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module binary_blob_contour_tracer_tb;

   localparam int WATCHDOG_LIMIT = 400000;
   localparam int ITEM_TARGET    = 1550;
   localparam int CALM_AFTER     = 1300;
   localparam int SETTLE_CYCLES  = 16;
   localparam int HOLD_CYCLES    = 300;

   typedef enum logic [1:0] {
      HD_UP    = 2'd0,
      HD_RIGHT = 2'd1,
      HD_DOWN  = 2'd2,
      HD_LEFT  = 2'd3
   } heading_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] x;
      logic [7:0] y;
      logic       pv;
   } pixel_cmd_type;

   typedef struct packed {
      logic [7:0]  point_x;
      logic [7:0]  point_y;
      logic [19:0] points_so_far;
      logic [1:0]  status;
      logic [1:0]  mask_value;
   } outline_point_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser  = bbct_pkg::KIND_LOAD;   // kind
   logic [23:0] req_tdata  = '0;          // coord_x, coord_y, pixel_value
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [1:0]  rsp_tuser;                // status
   logic [39:0] rsp_tdata;                // point_x, point_y, points_so_far, mask_value
   logic        csr_we     = 1'b0;
   logic        csr_addr   = bbct_pkg::CSR_WIDTH;
   logic [8:0]  csr_wdata  = '0;

   binary_blob_contour_tracer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // tracer state as the bench sees it
   bit [0:0]    img_store  [65536];
   bit [1:0]    mask_store [65536];
   int          cur_x, cur_y, org_x, org_y;
   heading_type heading    = HD_RIGHT;
   int unsigned pt_count;
   bit          trace_on;
   logic [8:0]  reg_w      = 9'd256;
   logic [8:0]  reg_h      = 9'd256;

   // what the stimulus has put into the image so far
   bit          plan_img   [65536];
   bit          written    [65536];

   pixel_cmd_type     pixel_cmds[$];
   outline_point_type expected_points[$];
   pixel_cmd_type     cmd_now;
   int             items_queued;
   int             items_taken;
   int             n_errors;
   int             idle_mode;      // 0 none, 1 light, 2 heavy
   bit             hold_request;
   int             quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int clamp_size(input logic [8:0] r);
      int v;
      v = r;
      if (v < 1) v = 1;
      if (v > 256) v = 256;
      return v;
   endfunction

   function automatic bit px(input int x, input int y);
      return img_store[y * 256 + x];
   endfunction

   function automatic void set_mark(input int x, input int y, input logic [1:0] code);
      mask_store[y * 256 + x] = code;
   endfunction

   function automatic void push_point(input int x, input int y, input logic [1:0] st,
                                      input logic [1:0] mv);
      outline_point_type p;
      p.point_x       = x[7:0];
      p.point_y       = y[7:0];
      p.points_so_far = pt_count[19:0];
      p.status        = st;
      p.mask_value    = mv;
      expected_points.push_back(p);
   endfunction

   task automatic advance_tracer(input pixel_cmd_type c);
      int       w, h, cx, cy, x, y, nx, ny;
      bit       at_start;
      heading_type nh;
      logic [1:0] res;
      w  = clamp_size(reg_w);
      h  = clamp_size(reg_h);
      cx = c.x;
      cy = c.y;
      case (c.kind)
         bbct_pkg::KIND_LOAD: begin
            img_store[cy * 256 + cx]  = c.pv;
            mask_store[cy * 256 + cx] = bbct_pkg::MK_NONE;
         end
         bbct_pkg::KIND_MASK:
            push_point(cx, cy, bbct_pkg::ST_MASK, mask_store[cy * 256 + cx]);
         bbct_pkg::KIND_START: begin
            trace_on = 1'b0;
            if (cx >= w || cy >= h) begin
               pt_count = 0;
               push_point(cx, cy, bbct_pkg::ST_OOB, bbct_pkg::MK_NONE);
            end else begin
               org_x = cx;
               org_y = cy;
               cur_x = cx;
               cur_y = cy;
               heading = HD_RIGHT;
               pt_count = 1;
               set_mark(cx, cy, bbct_pkg::MK_LEFT);
               if ((cy == 0 || !px(cx, cy - 1)) && (cx == w - 1 || !px(cx + 1, cy)) &&
                   (cy == h - 1 || !px(cx, cy + 1)) && (cx == 0 || !px(cx - 1, cy))) begin
                  // lone pixel: trace is over as soon as it starts
                  if (cx < w - 1) set_mark(cx + 1, cy, bbct_pkg::MK_RIGHT);
                  push_point(cx, cy, bbct_pkg::ST_DONE, bbct_pkg::MK_NONE);
               end else begin
                  trace_on = 1'b1;
                  push_point(cx, cy, bbct_pkg::ST_POINT, bbct_pkg::MK_NONE);
               end
            end
         end
         default: begin
            if (!trace_on) begin
               push_point(cur_x, cur_y, bbct_pkg::ST_DONE, bbct_pkg::MK_NONE);
            end else if (cur_x >= w || cur_y >= h) begin
               trace_on = 1'b0;
               push_point(cur_x, cur_y, bbct_pkg::ST_OOB, bbct_pkg::MK_NONE);
            end else begin
               x = cur_x;
               y = cur_y;
               at_start = (x == org_x && y == org_y);
               nx = x;
               ny = y;
               nh = heading;
               res = bbct_pkg::ST_POINT;
               case (heading)
                  HD_UP: begin
                     if (x > 0 && px(x - 1, y)) begin
                        nx = x - 1; nh = HD_LEFT;
                     end else begin
                        set_mark(x, y, bbct_pkg::MK_LEFT);
                        if (y > 0 && px(x, y - 1)) begin
                           ny = y - 1; nh = HD_UP;
                        end else if (at_start) begin
                           res = bbct_pkg::ST_DONE;
                        end else if (x < w - 1 && px(x + 1, y)) begin
                           nx = x + 1; nh = HD_RIGHT;
                        end else begin
                           if (x < w - 1) set_mark(x + 1, y, bbct_pkg::MK_RIGHT);
                           if (y >= h - 1) res = bbct_pkg::ST_OOB;
                           else begin
                              ny = y + 1; nh = HD_DOWN;
                           end
                        end
                     end
                  end
                  HD_RIGHT: begin
                     if (y > 0 && px(x, y - 1)) begin
                        ny = y - 1; nh = HD_UP;
                     end else if (at_start && pt_count > 1) begin
                        res = bbct_pkg::ST_DONE;
                     end else if (x < w - 1 && px(x + 1, y)) begin
                        nx = x + 1; nh = HD_RIGHT;
                     end else begin
                        if (x < w - 1) set_mark(x + 1, y, bbct_pkg::MK_RIGHT);
                        if (y < h - 1 && px(x, y + 1)) begin
                           ny = y + 1; nh = HD_DOWN;
                        end else if (x == 0) begin
                           res = bbct_pkg::ST_OOB;
                        end else begin
                           nx = x - 1; nh = HD_LEFT;
                        end
                     end
                  end
                  HD_DOWN: begin
                     if (at_start) begin
                        res = bbct_pkg::ST_DONE;
                     end else if (x < w - 1 && px(x + 1, y)) begin
                        nx = x + 1; nh = HD_RIGHT;
                     end else begin
                        if (x < w - 1) set_mark(x + 1, y, bbct_pkg::MK_RIGHT);
                        if (y < h - 1 && px(x, y + 1)) begin
                           ny = y + 1; nh = HD_DOWN;
                        end else if (x > 0 && px(x - 1, y)) begin
                           nx = x - 1; nh = HD_LEFT;
                        end else begin
                           set_mark(x, y, bbct_pkg::MK_LEFT);
                           if (y == 0) res = bbct_pkg::ST_OOB;
                           else begin
                              ny = y - 1; nh = HD_UP;
                           end
                        end
                     end
                  end
                  default: begin
                     if (y < h - 1 && px(x, y + 1)) begin
                        ny = y + 1; nh = HD_DOWN;
                     end else if (x > 0 && px(x - 1, y)) begin
                        nx = x - 1; nh = HD_LEFT;
                     end else begin
                        set_mark(x, y, bbct_pkg::MK_LEFT);
                        if (y > 0 && px(x, y - 1)) begin
                           ny = y - 1; nh = HD_UP;
                        end else if (at_start) begin
                           res = bbct_pkg::ST_DONE;
                        end else if (x >= w - 1) begin
                           res = bbct_pkg::ST_OOB;
                        end else begin
                           nx = x + 1; nh = HD_RIGHT;
                        end
                     end
                  end
               endcase
               if (res != bbct_pkg::ST_POINT) begin
                  trace_on = 1'b0;
                  push_point(cur_x, cur_y, res, bbct_pkg::MK_NONE);
               end else begin
                  cur_x = nx;
                  cur_y = ny;
                  heading = nh;
                  if (pt_count < 32'hFFFFF) pt_count++;
                  push_point(cur_x, cur_y, bbct_pkg::ST_POINT, bbct_pkg::MK_NONE);
               end
            end
         end
      endcase
   endtask

   // request side
   always @(posedge clock) begin : req_drive
      int gap;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tuser  <= bbct_pkg::KIND_LOAD;
         req_tdata  <= '0;
         gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            advance_tracer(cmd_now);
            items_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap > 0) begin
               gap--;
               req_tvalid <= 1'b0;
            end else if (idle_mode != 0 &&
                         $urandom_range(0, idle_mode == 1 ? 9 : 3) == 0) begin
               gap = $urandom_range(0, 4);
               req_tvalid <= 1'b0;
            end else if (pixel_cmds.size() != 0) begin
               cmd_now = pixel_cmds.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= cmd_now.kind;
               req_tdata  <= {7'd0, cmd_now.pv, cmd_now.y, cmd_now.x};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response ready, with short stalls and one long hold-off
   always @(posedge clock) begin : rsp_ready
      int stall_left;
      int hold_left;
      bit hold_done;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
         hold_left  = 0;
      end else begin
         if (hold_request && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (idle_mode != 0 &&
                      $urandom_range(0, idle_mode == 1 ? 9 : 3) == 0) begin
            stall_left = $urandom_range(0, 4);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      outline_point_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_points.size() == 0) begin
            $error("result with nothing expected: status %0d, tdata %h", rsp_tuser, rsp_tdata);
            n_errors++;
         end else begin
            want = expected_points.pop_front();
            if (rsp_tdata[7:0] !== want.point_x) begin
               $error("point_x: expected %0d, got %0d", want.point_x, rsp_tdata[7:0]);
               n_errors++;
            end
            if (rsp_tdata[15:8] !== want.point_y) begin
               $error("point_y: expected %0d, got %0d", want.point_y, rsp_tdata[15:8]);
               n_errors++;
            end
            if (rsp_tdata[35:16] !== want.points_so_far) begin
               $error("points_so_far: expected %0d, got %0d", want.points_so_far,
                      rsp_tdata[35:16]);
               n_errors++;
            end
            if (rsp_tuser !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_tuser);
               n_errors++;
            end
            if (rsp_tdata[37:36] !== want.mask_value) begin
               $error("mask_value: expected %0d, got %0d", want.mask_value, rsp_tdata[37:36]);
               n_errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic queue_cmd(input logic [1:0] kind, input int x, input int y, input bit pv);
      pixel_cmd_type c;
      c.kind = kind;
      c.x    = x[7:0];
      c.y    = y[7:0];
      c.pv   = pv;
      pixel_cmds.push_back(c);
      items_queued++;
      if (kind == bbct_pkg::KIND_LOAD) begin
         plan_img[y * 256 + x] = pv;
         written[y * 256 + x]  = 1'b1;
      end
   endtask

   task automatic queue_random(input logic [1:0] kind);
      queue_cmd(kind, $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 1));
   endtask

   task automatic wait_taken();
      while (pixel_cmds.size() != 0 || items_taken != items_queued) @(negedge clock);
   endtask

   // loads give no result, so the last one may still be in flight: pause after
   task automatic settle();
      wait_taken();
      while (expected_points.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic addr, input logic [8:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      if (addr == bbct_pkg::CSR_WIDTH) reg_w = value;
      else reg_h = value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic bit region_written(input int w, input int h);
      for (int y = 0; y < h; y++)
         for (int x = 0; x < w; x++)
            if (!written[y * 256 + x]) return 1'b0;
      return 1'b1;
   endfunction

   // one rectangular blob with holes, plus background noise
   task automatic fill_image(input int w, input int h);
      int x0, x1, y0, y1, noise, holes;
      bit v;
      x0 = $urandom_range(0, w - 1);
      x1 = $urandom_range(x0, w - 1);
      y0 = $urandom_range(0, h - 1);
      y1 = $urandom_range(y0, h - 1);
      noise = $urandom_range(0, 35);
      holes = $urandom_range(0, 20);
      for (int y = 0; y < h; y++)
         for (int x = 0; x < w; x++) begin
            if (x >= x0 && x <= x1 && y >= y0 && y <= y1)
               v = ($urandom_range(0, 99) >= holes);
            else
               v = ($urandom_range(0, 99) < noise);
            queue_cmd(bbct_pkg::KIND_LOAD, x, y, v);
         end
   endtask

   task automatic run_trace(input int w, input int h);
      int edges[$];
      int sx, sy, k, step_cap, steps;
      for (int y = 0; y < h; y++)
         for (int x = 0; x < w; x++)
            if (plan_img[y * 256 + x] && (x == 0 || !plan_img[y * 256 + x - 1]))
               edges.push_back(y * 256 + x);
      if (edges.size() != 0 && $urandom_range(0, 4) != 0) begin
         k  = edges[$urandom_range(0, edges.size() - 1)];
         sx = k % 256;
         sy = k / 256;
      end else if ($urandom_range(0, 1) == 1) begin
         sx = $urandom_range(0, 255);
         sy = $urandom_range(0, 255);
      end else begin
         sx = $urandom_range(0, w - 1);
         sy = $urandom_range(0, h - 1);
      end
      queue_cmd(bbct_pkg::KIND_START, sx, sy, $urandom_range(0, 1));
      step_cap = 4 * w * h + 8;
      if (step_cap > 400) step_cap = 400;
      steps = 0;
      do begin
         repeat (6) queue_random(bbct_pkg::KIND_STEP);
         steps += 6;
         wait_taken();
      end while (trace_on && steps < step_cap);
   endtask

   task automatic add_noise(input int w, input int h);
      repeat ($urandom_range(2, 5)) begin
         case ($urandom_range(0, 4))
            0: queue_cmd(bbct_pkg::KIND_MASK, $urandom_range(0, w - 1),
                         $urandom_range(0, h - 1), $urandom_range(0, 1));
            1: queue_random(bbct_pkg::KIND_MASK);
            2: queue_random(bbct_pkg::KIND_LOAD);
            3: queue_cmd(bbct_pkg::KIND_LOAD, $urandom_range(0, w - 1),
                         $urandom_range(0, h - 1), $urandom_range(0, 1));
            default: queue_random(bbct_pkg::KIND_STEP);
         endcase
      end
   endtask

   initial begin : stimulus
      int phase, w, h;
      logic [8:0] wreg, hreg;
      bit shrink;
      idle_mode = 2;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // at reset: step with no trace, mask reads at both corners
      queue_cmd(bbct_pkg::KIND_STEP, 0, 0, 1'b0);
      queue_cmd(bbct_pkg::KIND_MASK, 255, 255, 1'b1);
      queue_cmd(bbct_pkg::KIND_MASK, 0, 0, 1'b0);
      settle();
      write_reg(bbct_pkg::CSR_WIDTH, 9'd3);
      write_reg(bbct_pkg::CSR_HEIGHT, 9'd3);

      // 2x2 blob at the top left, lone pixel at the bottom right
      for (int y = 0; y < 3; y++)
         for (int x = 0; x < 3; x++)
            queue_cmd(bbct_pkg::KIND_LOAD, x, y, (x < 2 && y < 2) || (x == 2 && y == 2));
      queue_cmd(bbct_pkg::KIND_START, 2, 2, 1'b0);      // lone pixel
      queue_cmd(bbct_pkg::KIND_START, 5, 1, 1'b0);      // outside the image
      queue_cmd(bbct_pkg::KIND_START, 1, 1, 1'b0);
      queue_cmd(bbct_pkg::KIND_START, 0, 0, 1'b1);      // abandons the previous trace
      repeat (6) queue_cmd(bbct_pkg::KIND_STEP, 255, 255, 1'b1);
      queue_cmd(bbct_pkg::KIND_MASK, 0, 0, 1'b0);
      queue_cmd(bbct_pkg::KIND_MASK, 1, 0, 1'b0);
      queue_cmd(bbct_pkg::KIND_MASK, 2, 0, 1'b0);
      queue_cmd(bbct_pkg::KIND_LOAD, 255, 255, 1'b1);
      queue_cmd(bbct_pkg::KIND_LOAD, 255, 0, 1'b0);

      w = 3;
      h = 3;
      phase = 0;
      while (items_queued < ITEM_TARGET) begin
         phase++;
         settle();
         idle_mode = (items_queued > CALM_AFTER) ? 0 : $urandom_range(0, 2);
         shrink = 1'b0;
         if (phase == 3) begin
            wreg = 9'd511;      // clamps to 256 columns
            hreg = 9'd1;
         end else if (phase == 6) begin
            wreg = 9'd0;        // clamps to one column
            hreg = 9'd256;
         end else if ($urandom_range(0, 3) == 0) begin
            shrink = 1'b1;
            wreg = $urandom_range(1, w);
            hreg = $urandom_range(1, h);
         end else begin
            wreg = $urandom_range(1, 9);
            hreg = $urandom_range(1, 9);
         end
         write_reg(bbct_pkg::CSR_WIDTH, wreg);
         write_reg(bbct_pkg::CSR_HEIGHT, hreg);
         w = clamp_size(wreg);
         h = clamp_size(hreg);
         if (region_written(w, h)) begin
            // a trace left running may now sit outside the smaller image
            repeat (2) queue_random(bbct_pkg::KIND_STEP);
            if (!shrink && $urandom_range(0, 3) != 0) fill_image(w, h);
         end else begin
            fill_image(w, h);
         end
         if (phase == 1) hold_request = 1'b1;
         repeat ($urandom_range(1, 3)) begin
            run_trace(w, h);
            add_noise(w, h);
         end
      end

      wait_taken();
      while (expected_points.size() != 0) @(negedge clock);
      repeat (30) @(negedge clock);
      if (n_errors == 0 && expected_points.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
sv/bbct_pkg.sv
sv/bbct_ctrl.sv
sv/bbct_dp.sv
sv/binary_blob_contour_tracer.sv
bench/binary_blob_contour_tracer_tb.sv
